>>> src/stoi_pkg.sv
// Shared types and constants for the streaming signed integer parser.
// Has no dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package stoi_pkg;

  // Default widths of the value datapath and the position counter.
  localparam int VALUE_BITS_DEF    = 64;
  localparam int POSITION_BITS_DEF = 16;

  // Depth of the queue between the classifier and the executor.
  localparam int QUEUE_DEPTH = 2;

  // Character codes.
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] LO_OFFSET = 8'h61 - 8'd10;
  localparam logic [7:0] UP_OFFSET = 8'h41 - 8'd10;

  // Bases.
  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_ONE  = 6'd1;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;
  localparam logic [5:0] BASE_MAX  = 6'd36;

  // Digit code of a character that is no digit in any base.
  localparam logic [5:0] NOT_DIGIT = 6'h3F;

  // One input item.
  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic [5:0] radix;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [63:0] value;
    logic [15:0]        end_offset;
    logic               overflow;
    logic               converted;
  } out_item_t;

  // A classified character as it travels from the front to the back.
  typedef struct packed {
    logic       first;
    logic [5:0] radix;
    logic [5:0] digit;
    logic       is_space;
    logic       is_minus;
    logic       is_plus;
    logic       is_x;
    logic       is_zero;
  } cls_item_t;

endpackage

>>> src/stoi_front.sv
// Front stage: accepts input items and classifies each character.
// Depends on stoi_pkg for the item types and character codes.
`timescale 1ns / 1ps

module stoi_front
  import stoi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      cls_valid,
  input  logic      cls_full,
  output cls_item_t cls_item
);

  logic      valid_r;
  logic      valid_nxt;
  cls_item_t item_r;
  cls_item_t item_nxt;
  logic      accept;
  logic      push;

  // The stage holds one item and frees up whenever the queue takes it.
  assign push     = valid_r && !cls_full;
  assign in_stall = valid_r && cls_full;
  assign accept   = in_valid && !in_stall;

  // Classify the character of the incoming item.
  always_comb begin
    item_nxt.first    = in_item.first;
    item_nxt.radix    = in_item.radix;
    item_nxt.is_space = (in_item.ch == CH_SPACE) ||
                        ((in_item.ch >= CH_TAB) && (in_item.ch <= CH_CR));
    item_nxt.is_minus = (in_item.ch == CH_MINUS);
    item_nxt.is_plus  = (in_item.ch == CH_PLUS);
    item_nxt.is_x     = (in_item.ch == CH_LO_X) || (in_item.ch == CH_UP_X);
    item_nxt.is_zero  = (in_item.ch == CH_ZERO);
    if (in_item.ch inside {[CH_ZERO:CH_NINE]}) begin
      item_nxt.digit = 6'(in_item.ch - CH_ZERO);
    end else if (in_item.ch inside {[CH_LO_A:CH_LO_Z]}) begin
      item_nxt.digit = 6'(in_item.ch - LO_OFFSET);
    end else if (in_item.ch inside {[CH_UP_A:CH_UP_Z]}) begin
      item_nxt.digit = 6'(in_item.ch - UP_OFFSET);
    end else begin
      item_nxt.digit = NOT_DIGIT;
    end
  end

  assign valid_nxt = (valid_r && !push) || accept;

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign cls_valid = valid_r;
  assign cls_item  = item_r;

endmodule

>>> src/stoi_queue.sv
// Short queue of classified items between the front and the back.
// Depends on stoi_pkg for the item type and the queue depth.
`timescale 1ns / 1ps

module stoi_queue
  import stoi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output cls_item_t head_item
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  cls_item_t           slot_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;
  logic                do_push;
  logic                do_pop;

  assign full      = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Pointer and fill count update, wrapping at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> src/stoi_back.sv
// Back end: runs the parse state machine on classified items, accumulates
// the value with a two-step multiply then add-and-compare, and holds the result.
// Depends on stoi_pkg for the item types and base constants.
`timescale 1ns / 1ps

module stoi_back
  import stoi_pkg::*;
#(
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cls_item_t q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int PROD_BITS = VALUE_BITS + 6;
  localparam int EXT_BITS  = (POSITION_BITS > 16) ? POSITION_BITS : 16;
  localparam logic [VALUE_BITS-1:0] HALF = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS
  } phase_t;

  phase_t                   phase_r, phase_nxt, c_phase;
  logic                     neg_r, neg_nxt, c_neg;
  logic [VALUE_BITS-1:0]    acc_r, acc_nxt, c_acc;
  logic                     conv_r, conv_nxt, c_conv;
  logic                     over_r, over_nxt, c_over;
  logic [5:0]               base_r, base_nxt, c_base;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, c_pos;
  logic [POSITION_BITS-1:0] mark_r, mark_nxt, c_mark;
  logic                     mul_r, mul_nxt;
  logic [PROD_BITS-1:0]     prod_r, prod_nxt;
  logic [5:0]               dig_r, dig_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_item_r, out_item_nxt;

  logic                     do_take;
  logic                     do_fin;
  logic [POSITION_BITS-1:0] fin_pos;
  logic [EXT_BITS-1:0]      fin_ext;
  logic [5:0]               t_base;
  logic [PROD_BITS-1:0]     sum;
  logic [PROD_BITS-1:0]     lim;
  logic signed [VALUE_BITS-1:0] fin_val;

  // An item leaves the queue only when no accumulate step is pending and
  // the result register is free to take a possible result.
  assign q_pop = q_valid && !mul_r && !(out_valid_r && out_stall);

  // Second step of a digit: add the digit and check against the signed limit.
  assign sum = prod_r + PROD_BITS'(dig_r);
  assign lim = PROD_BITS'(neg_r ? HALF : HALF - 1'b1);

  // Parse state machine, one item per pass.
  always_comb begin
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    conv_nxt      = conv_r;
    over_nxt      = over_r;
    base_nxt      = base_r;
    pos_nxt       = pos_r;
    mark_nxt      = mark_r;
    mul_nxt       = 1'b0;
    prod_nxt      = prod_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;

    c_phase = phase_r;
    c_neg   = neg_r;
    c_acc   = acc_r;
    c_conv  = conv_r;
    c_over  = over_r;
    c_base  = base_r;
    c_pos   = pos_r;
    c_mark  = mark_r;
    do_take = 1'b0;
    do_fin  = 1'b0;
    fin_pos = pos_r;
    t_base  = base_r;
    fin_val = '0;
    fin_ext = '0;

    if (mul_r) begin
      // Overflow is sticky; later digits still move the end position.
      if (over_r || (sum > lim)) begin
        over_nxt = 1'b1;
      end else begin
        acc_nxt = sum[VALUE_BITS-1:0];
      end
      conv_nxt = 1'b1;
    end else if (q_pop) begin
      // A first-character flag restarts the parse from a clean state.
      if (q_item.first) begin
        c_phase = PH_LEAD;
        c_neg   = 1'b0;
        c_acc   = '0;
        c_conv  = 1'b0;
        c_over  = 1'b0;
        c_base  = q_item.radix;
        c_pos   = '0;
        c_mark  = '0;
      end else if (phase_r != PH_IDLE) begin
        c_pos = (pos_r == {POSITION_BITS{1'b1}}) ? pos_r : pos_r + 1'b1;
      end
      fin_pos = c_pos;

      if (q_item.first && ((q_item.radix == BASE_ONE) || (q_item.radix > BASE_MAX))) begin
        // Invalid base: end at once with nothing converted.
        do_fin = 1'b1;
      end else begin
        case (c_phase)
          PH_LEAD, PH_SIGNED: begin
            if ((c_phase == PH_LEAD) && q_item.is_space) begin
              c_phase = PH_LEAD;
            end else if ((c_phase == PH_LEAD) && (q_item.is_minus || q_item.is_plus)) begin
              c_neg   = q_item.is_minus;
              c_phase = PH_SIGNED;
            end else if (q_item.is_zero &&
                         ((c_base == BASE_AUTO) || (c_base == BASE_HEX))) begin
              // A leading zero may open a hex prefix or pick octal.
              c_acc   = '0;
              c_conv  = 1'b1;
              c_phase = PH_ZERO;
            end else begin
              t_base = (c_base == BASE_AUTO) ? BASE_DEC : c_base;
              c_base = t_base;
              if (q_item.digit < t_base) begin
                do_take = 1'b1;
              end else begin
                do_fin = 1'b1;
              end
            end
          end
          PH_ZERO: begin
            if (q_item.is_x) begin
              c_base  = BASE_HEX;
              c_mark  = c_pos;
              c_phase = PH_PREFIX;
            end else begin
              t_base = (c_base == BASE_AUTO) ? BASE_OCT : c_base;
              c_base = t_base;
              if (q_item.digit < t_base) begin
                do_take = 1'b1;
              end else begin
                do_fin = 1'b1;
              end
            end
          end
          PH_PREFIX: begin
            // A bare prefix ends at the 'x', having converted the zero.
            if (q_item.digit < c_base) begin
              do_take = 1'b1;
            end else begin
              do_fin  = 1'b1;
              fin_pos = c_mark;
            end
          end
          PH_DIGITS: begin
            if (q_item.digit < c_base) begin
              do_take = 1'b1;
            end else begin
              do_fin = 1'b1;
            end
          end
          default: begin
            c_phase = PH_IDLE;
          end
        endcase
      end

      // First step of a digit: multiply the accumulator by the base.
      if (do_take) begin
        c_phase  = PH_DIGITS;
        mul_nxt  = 1'b1;
        prod_nxt = PROD_BITS'(c_acc) * PROD_BITS'(c_base);
        dig_nxt  = q_item.digit;
      end

      // End of the parse: build the result.
      if (do_fin) begin
        if (c_over) begin
          fin_val = c_neg ? HALF : HALF - 1'b1;
        end else if (c_neg) begin
          fin_val = -c_acc;
        end else begin
          fin_val = c_acc;
        end
        fin_ext = c_conv ? EXT_BITS'(fin_pos) : '0;
        out_item_nxt.value      = 64'(fin_val);
        out_item_nxt.end_offset = (fin_ext > EXT_BITS'(16'hFFFF)) ? 16'hFFFF : fin_ext[15:0];
        out_item_nxt.overflow   = c_over;
        out_item_nxt.converted  = c_conv;
        out_valid_nxt           = 1'b1;
        c_phase                 = PH_IDLE;
      end

      phase_nxt = c_phase;
      neg_nxt   = c_neg;
      acc_nxt   = c_acc;
      conv_nxt  = c_conv;
      over_nxt  = c_over;
      base_nxt  = c_base;
      pos_nxt   = c_pos;
      mark_nxt  = c_mark;
    end
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      conv_r      <= 1'b0;
      over_r      <= 1'b0;
      base_r      <= '0;
      pos_r       <= '0;
      mark_r      <= '0;
      mul_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      conv_r      <= conv_nxt;
      over_r      <= over_nxt;
      base_r      <= base_nxt;
      pos_r       <= pos_nxt;
      mark_r      <= mark_nxt;
      mul_r       <= mul_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prod_r     <= prod_nxt;
    dig_r      <= dig_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> src/string_to_signed_integer_parser.sv
// Top level of the streaming signed integer parser (bases 2 to 36).
// Depends on stoi_pkg, stoi_front, stoi_queue and stoi_back.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   in_item  (in_item_t)
//   out_     output     out_valid / out_stall out_item (out_item_t)
//
// In the back end a digit is handled as a multiply by the base and then an
// add and limit compare; any other character is handled without these steps.
// An item passes the classifier register and a two-entry queue first, and the
// result is held in the back end's output register; it is delayed further when the
// character ending the parse waits behind a digit's second step.
// Reset is synchronous, active low, and clears all control state at once.
// A stalled result holds in the output register while the front keeps taking
// items until the queue and the classifier register are full.
`timescale 1ns / 1ps

module string_to_signed_integer_parser
  import stoi_pkg::*;
#(
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      cls_valid;
  logic      q_full;
  cls_item_t cls_item;
  logic      q_pop;
  logic      q_not_empty;
  cls_item_t q_head;

  // Classifier.
  stoi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cls_valid (cls_valid),
    .cls_full  (q_full),
    .cls_item  (cls_item)
  );

  // Queue between classifier and executor.
  stoi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cls_valid),
    .push_item (cls_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (q_head)
  );

  // Parse executor and result register.
  stoi_back #(
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> tb/parse_checker.sv
// Scoreboard for the streaming signed integer parser: predicts each result from the
// accepted characters and compares it with what leaves the result channel.
// Depends on stoi_pkg for the item types and character codes.
`timescale 1ns / 1ps

module parse_checker
  import stoi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending,
  output int        results_checked,
  output int        saturated_count
);

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_LEAD, SCAN_SIGNED, SCAN_ZERO, SCAN_PREFIX, SCAN_DIGITS
  } scan_state_t;

  typedef enum logic [1:0] {DIG_NONE, DIG_OK, DIG_OVER} digit_state_t;

  localparam logic [63:0] SIGN_BIT   = 64'h8000_0000_0000_0000;
  localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

  // Predicted parser state.
  scan_state_t  scan = SCAN_IDLE;
  digit_state_t dig = DIG_NONE;
  logic         neg = 1'b0;
  logic [63:0]  acc = '0;
  logic [5:0]   base = '0;
  logic [15:0]  offset = '0;
  logic [15:0]  x_offset = '0;

  out_item_t parsed_q[$];
  int        fails = 0;
  int        checked = 0;
  int        saturated = 0;

  // Digit value of a character, or a code above every base.
  function automatic logic [5:0] char_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CH_ZERO && c <= CH_NINE) v = c - CH_ZERO;
    else if (c >= CH_LO_A && c <= CH_LO_Z) v = c - LO_OFFSET;
    else if (c >= CH_UP_A && c <= CH_UP_Z) v = c - UP_OFFSET;
    else v = {2'b00, NOT_DIGIT};
    return v[5:0];
  endfunction

  // Takes the character as a digit if it is one in the current base; once the
  // magnitude leaves the signed range further digits are taken but not added.
  function automatic bit take_digit(input logic [7:0] c);
    logic [5:0]  d;
    logic [63:0] limit;
    logic [63:0] cut_val;
    logic [63:0] cut_dig;
    d = char_value(c);
    if (d >= base) return 1'b0;
    limit   = neg ? SIGN_BIT : SIGN_BIT - 64'd1;
    cut_val = limit / base;
    cut_dig = limit % base;
    if (dig == DIG_OVER || acc > cut_val || (acc == cut_val && d > cut_dig)) begin
      dig = DIG_OVER;
    end else begin
      acc = acc * base + d;
      dig = DIG_OK;
    end
    return 1'b1;
  endfunction

  // Ends the parse and queues its result.
  function automatic void close_parse(input logic [15:0] end_at);
    out_item_t r;
    r.converted = (dig != DIG_NONE);
    r.overflow  = (dig == DIG_OVER);
    if (r.overflow) r.value = neg ? SIGN_BIT : SIGN_BIT - 64'd1;
    else if (neg) r.value = -acc;
    else r.value = acc;
    r.end_offset = r.converted ? end_at : 16'd0;
    parsed_q.push_back(r);
    scan = SCAN_IDLE;
  endfunction

  // First character of the number itself, after any space and sign.
  function automatic void start_number(input logic [7:0] c);
    if (c == CH_ZERO && (base == BASE_AUTO || base == BASE_HEX)) begin
      acc  = '0;
      dig  = DIG_OK;
      scan = SCAN_ZERO;
    end else begin
      if (base == BASE_AUTO) base = BASE_DEC;
      if (take_digit(c)) scan = SCAN_DIGITS;
      else close_parse(offset);
    end
  endfunction

  function automatic void predict_char(input in_item_t it);
    logic [7:0] c;
    c = it.ch;
    if (it.first) begin
      scan     = SCAN_LEAD;
      neg      = 1'b0;
      acc      = '0;
      dig      = DIG_NONE;
      base     = it.radix;
      offset   = '0;
      x_offset = '0;
      if (it.radix == BASE_ONE || it.radix > BASE_MAX) begin
        close_parse(16'd0);
        return;
      end
    end else begin
      if (scan == SCAN_IDLE) return;
      if (offset != OFFSET_MAX) offset = offset + 16'd1;
    end
    case (scan)
      SCAN_LEAD: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          // Leading white space is skipped.
        end else if (c == CH_MINUS || c == CH_PLUS) begin
          neg  = (c == CH_MINUS);
          scan = SCAN_SIGNED;
        end else begin
          start_number(c);
        end
      end
      SCAN_SIGNED: start_number(c);
      SCAN_ZERO: begin
        if (c == CH_LO_X || c == CH_UP_X) begin
          base     = BASE_HEX;
          x_offset = offset;
          scan     = SCAN_PREFIX;
        end else begin
          if (base == BASE_AUTO) base = BASE_OCT;
          if (take_digit(c)) scan = SCAN_DIGITS;
          else close_parse(offset);
        end
      end
      // A bare prefix converts only the zero, so the end sits on the x.
      SCAN_PREFIX: begin
        if (take_digit(c)) scan = SCAN_DIGITS;
        else close_parse(x_offset);
      end
      SCAN_DIGITS: begin
        if (!take_digit(c)) close_parse(offset);
      end
      default: scan = SCAN_IDLE;
    endcase
  endfunction

  // Compare results first, then fold in the item accepted at the same edge.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if ($isunknown(out_valid) || $isunknown(in_stall)) begin
        fails++;
        if (fails <= 10) $display("Unknown value on out_valid or in_stall at %0t", $realtime);
      end
      if (out_valid && !out_stall) begin
        if (parsed_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("Result with none expected: value %0d offset %0d",
                                    out_item.value, out_item.end_offset);
        end else begin
          want = parsed_q.pop_front();
          checked++;
          if (want.overflow) saturated++;
          if (out_item.value !== want.value || out_item.end_offset !== want.end_offset ||
              out_item.overflow !== want.overflow ||
              out_item.converted !== want.converted) begin
            fails++;
            if (fails <= 10) begin
              $display("Result %0d expected value %0d offset %0d ovf %0b conv %0b", checked,
                       want.value, want.end_offset, want.overflow, want.converted);
              $display("Result %0d got      value %0d offset %0d ovf %0b conv %0b", checked,
                       out_item.value, out_item.end_offset, out_item.overflow,
                       out_item.converted);
            end
          end
        end
      end
      if (in_valid && !in_stall) predict_char(in_item);
    end
    fail_count      <= fails;
    pending         <= parsed_q.size();
    results_checked <= checked;
    saturated_count <= saturated;
  end

endmodule

>>> tb/testbench.sv
// Top of the parser testbench: clock, reset, character stimulus and result stall.
// Depends on stoi_pkg, parse_checker and the string_to_signed_integer_parser block.
`timescale 1ns / 1ps

module testbench;
  import stoi_pkg::*;

  localparam logic [7:0] CH_NUL = 8'h00;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int fails;
  int pending;
  int results_checked;
  int saturated_count;

  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit hold_request = 1'b0;
  int chars_sent = 0;
  int random_chars = 0;
  int strings_sent = 0;
  int in_stall_cycles = 0;

  // Characters of the string being built.
  logic [7:0] text_q[$];

  always #5 clk = ~clk;

  string_to_signed_integer_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  parse_checker u_parse_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .fail_count     (fails),
    .pending        (pending),
    .results_checked(results_checked),
    .saturated_count(saturated_count)
  );

  always @(posedge clk) begin
    if (in_valid && in_stall) in_stall_cycles++;
  end

  // Offers one item after a random gap and waits until it is taken.
  task automatic send_char(input in_item_t it);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sends the built string; the radix matters only on the first item.
  task automatic send_text(input logic [5:0] radix);
    in_item_t it;
    foreach (text_q[i]) begin
      it.ch    = text_q[i];
      it.first = (i == 0);
      it.radix = (i == 0) ? radix : 6'($urandom_range(0, 63));
      send_char(it);
      chars_sent++;
    end
    strings_sent++;
  endtask

  function automatic void put_chars(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [7:0] c;
    if (d < 10) c = CH_ZERO + d;
    else c = ($urandom_range(0, 1) ? UP_OFFSET : LO_OFFSET) + d;
    return c;
  endfunction

  // Appends the digits of a magnitude in the given base, letters in mixed case.
  function automatic void put_number(input logic [63:0] mag, input int radix);
    logic [7:0]  digs[$];
    logic [63:0] d;
    do begin
      d = mag % radix;
      digs.push_front(digit_char(d[5:0]));
      mag = mag / radix;
    end while (mag != 0);
    foreach (digs[i]) text_q.push_back(digs[i]);
  endfunction

  // Magnitudes weighted towards the edges of the signed range.
  function automatic logic [63:0] pick_magnitude();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1000);
      1: return r;
      2: return r >> $urandom_range(1, 63);
      3: return 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 2) + $urandom_range(0, 2);
      4: return 64'h8000_0000_0000_0000 + $urandom_range(0, 2) - $urandom_range(0, 2);
      default: return r | 64'h8000_0000_0000_0000;
    endcase
  endfunction

  // Builds a well-formed string with random content, sometimes cut short.
  function automatic logic [5:0] build_random_string();
    logic [5:0] radix;
    int         eb;
    int         sel;
    text_q.delete();
    sel = $urandom_range(0, 15);
    if (sel < 4) radix = BASE_AUTO;
    else if (sel < 6) radix = BASE_HEX;
    else if (sel < 8) radix = BASE_DEC;
    else if (sel == 8) radix = BASE_OCT;
    else if (sel == 9) radix = 6'd2;
    else if (sel == 10) radix = BASE_MAX;
    else if (sel == 14) radix = $urandom_range(0, 1) ? BASE_ONE : 6'($urandom_range(37, 63));
    else radix = 6'($urandom_range(2, 36));
    // Optional leading white space and sign.
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2))
        text_q.push_back($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13)));
    end
    case ($urandom_range(0, 2))
      1: text_q.push_back(CH_MINUS);
      2: text_q.push_back(CH_PLUS);
      default: ;
    endcase
    // Base and prefix.
    if (radix == BASE_AUTO) begin
      case ($urandom_range(0, 2))
        0: eb = 10;
        1: begin
          text_q.push_back(CH_ZERO);
          eb = 8;
        end
        default: begin
          text_q.push_back(CH_ZERO);
          text_q.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
          eb = 16;
        end
      endcase
    end else if (radix == BASE_HEX && $urandom_range(0, 1)) begin
      text_q.push_back(CH_ZERO);
      text_q.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
      eb = 16;
    end else if (radix == BASE_ONE || radix > BASE_MAX) begin
      eb = 10;
    end else begin
      eb = radix;
    end
    put_number(pick_magnitude(), eb);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(digit_char(6'($urandom_range(0, eb - 1))));
    end
    // Terminator.
    case ($urandom_range(0, 5))
      0: text_q.push_back(CH_NUL);
      1: text_q.push_back(CH_SPACE);
      2: text_q.push_back(8'($urandom_range(128, 255)));
      3: text_q.push_back(8'h2E);
      4: text_q.push_back(eb < 36 ? digit_char(6'($urandom_range(eb, 35))) : 8'h5F);
      default: text_q.push_back(8'($urandom_range(0, 255)));
    endcase
    // Now and then the string breaks off and the next one restarts the parse.
    if ($urandom_range(0, 9) == 0) begin
      sel = $urandom_range(1, text_q.size());
      while (text_q.size() > sel) text_q.delete(text_q.size() - 1);
    end
    return radix;
  endfunction

  // Receiver: random stall before each result, plus one long hold-off on request.
  initial begin : receiver
    int wait_n;
    wait (rst_n === 1'b1);
    forever begin
      wait_n = rx_gaps ? $urandom_range(0, 3) : 0;
      if (hold_request) begin
        wait_n = 400;
        hold_request = 1'b0;
      end
      @(negedge clk);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Overall time limit.
  initial begin : watchdog
    #15_000_000;
    $display("Timed out with %0d results outstanding", pending);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    in_item_t   it;
    logic [5:0] radix;
    bit         hold_done;
    hold_done = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // A character with no parse running is ignored.
    it.ch    = CH_UP_A;
    it.first = 1'b0;
    it.radix = BASE_DEC;
    send_char(it);
    // Invalid bases end at once with nothing converted.
    text_q = {8'h31};
    send_text(BASE_ONE);
    send_text(6'd63);
    // White space, sign and hex prefix under automatic base.
    text_q.delete();
    put_chars("\t-0x1F");
    text_q.push_back(8'hFF);
    send_text(BASE_AUTO);
    // Bare prefix, then a leading zero that selects octal.
    text_q.delete();
    put_chars("0Xg");
    send_text(BASE_HEX);
    text_q.delete();
    put_chars("08");
    send_text(BASE_AUTO);
    // Highest digit in both cases.
    text_q.delete();
    put_chars("Zz");
    text_q.push_back(CH_NUL);
    send_text(BASE_MAX);
    // A new string drops the open parse.
    text_q = {8'h31};
    send_text(6'd2);
    text_q.delete();
    put_chars("+9 ");
    send_text(BASE_DEC);
    // Sign with no digit after it.
    text_q.delete();
    put_chars("-.");
    send_text(BASE_AUTO);
    // Signed range limits in base 36.
    text_q.delete();
    put_number(64'h7FFF_FFFF_FFFF_FFFF, 36);
    text_q.push_back(CH_NUL);
    send_text(BASE_MAX);
    text_q = {CH_MINUS};
    put_number(64'h8000_0000_0000_0000, 36);
    text_q.push_back(CH_NUL);
    send_text(BASE_MAX);
    // A long run of zeros sent back to back.
    tx_gaps = 1'b0;
    text_q.delete();
    repeat (200) text_q.push_back(CH_ZERO);
    text_q.push_back(8'h3B);
    send_text(BASE_DEC);
    tx_gaps = 1'b1;

    // Random strings with some noise; one long receiver hold-off early on.
    while (random_chars < 950) begin
      if (strings_sent % 40 == 0) begin
        tx_gaps = $urandom_range(0, 3) != 0;
        rx_gaps = $urandom_range(0, 3) != 0;
      end
      if (!hold_done && strings_sent >= 30) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
        tx_gaps      = 1'b0;
      end
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          it.ch    = 8'($urandom_range(0, 255));
          it.first = ($urandom_range(0, 3) == 0);
          it.radix = 6'($urandom_range(0, 63));
          send_char(it);
        end
      end else begin
        radix = build_random_string();
        random_chars += text_q.size();
        send_text(radix);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain, then allow for the pipeline latency.
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Covered %0d characters in %0d strings plus noise; %0d results checked, %0d saturated.",
             chars_sent, strings_sent, results_checked, saturated_count);
    $display("Input was held off for %0d cycles, including one long output stall.",
             in_stall_cycles);
    if (fails == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      if (pending != 0) $display("%0d results never arrived", pending);
      $display("FAIL");
    end
    $finish;
  end

endmodule
